@@ src/nns_pkg.sv @@
package nns_pkg;

    // Register map, index = paddr[4:2]
    localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_DRAW_WIDTH    = 3'd2;
    localparam logic [2:0] REG_DRAW_HEIGHT   = 3'd3;
    localparam logic [2:0] REG_REGION_LEFT   = 3'd4;
    localparam logic [2:0] REG_REGION_TOP    = 3'd5;
    localparam logic [2:0] REG_LINE_PITCH    = 3'd6;

    // Request kinds carried in tuser
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_RENDER = 1'b1;

    localparam int SIZE_W  = 13;  // image and region sizes
    localparam int POS_W   = 12;  // coordinates and region offsets
    localparam int PITCH_W = 14;
    localparam int IDX_W   = 16;  // load index field
    localparam int RGB_W   = 24;
    localparam int PROD_W  = POS_W + SIZE_W;        // coordinate times size
    localparam int LIN_W   = 2 * SIZE_W;            // source row times width
    localparam int SUM_W   = LIN_W + 1;             // plus source column
    localparam int FPROD_W = SIZE_W + PITCH_W;      // absolute row times pitch
    localparam int ADDR_W  = 26;

    typedef struct packed {
        logic               req;
        logic [IDX_W-1:0]   idx;
        logic [RGB_W-1:0]   rgb;
        logic [POS_W-1:0]   col;
        logic [POS_W-1:0]   row;
        logic               in_draw;
    } t_item;

    typedef struct packed {
        t_item              item;
        logic [SIZE_W-1:0]  sy;
    } t_item_y;

    typedef struct packed {
        t_item              item;
        logic [FPROD_W-1:0] fprod;
        logic [SIZE_W-1:0]  colabs;
    } t_addr_part;

    // Clamp a scaled coordinate to the last row or column
    function automatic logic [SIZE_W-1:0] clamp_coord(
        input logic [SIZE_W-1:0] q,
        input logic [SIZE_W-1:0] size
    );
        logic [SIZE_W-1:0] res;
        res = q;
        if (q >= size) begin
            res = (size == '0) ? '0 : size - SIZE_W'(1);
        end
        return res;
    endfunction

endpackage

@@ src/nns_ram.sv @@
module nns_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/nns_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// The dividend's bits above QW must already be below the divisor.
module nns_div #(
    parameter int NW = 25,
    parameter int DW = 13,
    parameter int QW = 13,
    parameter int PW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    input  logic [PW-1:0] i_payload,
    output logic          o_valid,
    output logic [QW-1:0] o_quotient,
    output logic [DW-1:0] o_remainder,
    output logic [PW-1:0] o_payload
);

    logic [DW-1:0] s_rem [QW+1];
    logic [QW-1:0] s_qd  [QW+1];
    logic [PW-1:0] s_pay [QW+1];
    logic [QW:0]   s_vld;

    assign s_rem[0] = DW'(i_dividend >> QW);
    assign s_qd[0]  = i_dividend[QW-1:0];
    assign s_pay[0] = i_payload;
    assign s_vld[0] = i_valid;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          take;
        logic [DW-1:0] n_rem;
        logic [DW-1:0] r_rem;
        logic [QW-1:0] r_qd;
        logic [PW-1:0] r_pay;
        logic          r_vld;

        assign trial = {s_rem[k], s_qd[k][QW-1]};
        assign diff  = trial - {1'b0, i_divisor};
        assign take  = (trial >= {1'b0, i_divisor});
        assign n_rem = take ? diff[DW-1:0] : trial[DW-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= n_rem;
                r_qd  <= (s_qd[k] << 1) | QW'(take);
                r_pay <= s_pay[k];
            end
        end

        assign s_rem[k+1] = r_rem;
        assign s_qd[k+1]  = r_qd;
        assign s_pay[k+1] = r_pay;
        assign s_vld[k+1] = r_vld;
    end

    assign o_valid     = s_vld[QW];
    assign o_quotient  = s_qd[QW];
    assign o_remainder = s_rem[QW];
    assign o_payload   = s_pay[QW];

endmodule

@@ src/nearest_neighbor_scale_blit.sv @@
// Nearest-neighbor scaler from a stored source image into a framebuffer region.
// Input stream (s_axis_*): tuser[0] selects the kind of item. A load item writes
// one RGB pixel into the source store at pixel_index; a render item names an
// output pixel (out_col, out_row) of the drawing region and returns its framebuffer
// word address and the chosen source pixel as XRGB8888 with the top byte dropped.
// Renders outside the region and all loads give no output item.
// Output stream (m_axis_*): one item per in-region render, in input order.
// The user must write configuration over APB only while the block is idle; the
// block itself does not enforce this. Throughput: one item per clock while the
// receiver does not stall. Items pass two 13-stage bit-per-cycle dividers (row,
// then column) plus the multiply, address and store-read stages; when SOURCE_PIXELS
// is not a power of two a further 3-stage reciprocal reduction of the store index
// is inserted.
// Loads write the store at the same stage where renders read it, so order holds.
// Reset clears the registers to their defaults and empties the pipeline; the
// store keeps no reset value. When the receiver stalls, the whole pipeline holds
// and s_axis_tready drops until the output register can move.
module nearest_neighbor_scale_blit #(
    parameter int SOURCE_PIXELS = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] pixel_index, [23:16] red_in, [31:24] green_in, [39:32] blue_in,
    // [51:40] out_col, [63:52] out_row
    input  logic [63:0] s_axis_tdata,
    // [0] req_type
    input  logic [0:0]  s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [25:0] frame_address, [49:26] xrgb_pixel, [55:50] zero
    output logic [55:0] m_axis_tdata,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import nns_pkg::*;

    localparam int  IW   = $clog2(SOURCE_PIXELS);
    localparam bit  POW2 = ((SOURCE_PIXELS & (SOURCE_PIXELS - 1)) == 0);
    localparam int  MW   = IW + 1;

    // ---------------- configuration registers ----------------
    logic [SIZE_W-1:0]  r_src_w, r_src_h, r_draw_w, r_draw_h;
    logic [POS_W-1:0]   r_left, r_top;
    logic [PITCH_W-1:0] r_pitch;
    logic [2:0]         cfg_idx;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w  <= SIZE_W'(1);
            r_src_h  <= SIZE_W'(1);
            r_draw_w <= SIZE_W'(1);
            r_draw_h <= SIZE_W'(1);
            r_left   <= '0;
            r_top    <= '0;
            r_pitch  <= PITCH_W'(1);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SOURCE_WIDTH:  r_src_w  <= pwdata[SIZE_W-1:0];
                REG_SOURCE_HEIGHT: r_src_h  <= pwdata[SIZE_W-1:0];
                REG_DRAW_WIDTH:    r_draw_w <= pwdata[SIZE_W-1:0];
                REG_DRAW_HEIGHT:   r_draw_h <= pwdata[SIZE_W-1:0];
                REG_REGION_LEFT:   r_left   <= pwdata[POS_W-1:0];
                REG_REGION_TOP:    r_top    <= pwdata[POS_W-1:0];
                REG_LINE_PITCH:    r_pitch  <= pwdata[PITCH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SOURCE_WIDTH:  prdata = 32'(r_src_w);
            REG_SOURCE_HEIGHT: prdata = 32'(r_src_h);
            REG_DRAW_WIDTH:    prdata = 32'(r_draw_w);
            REG_DRAW_HEIGHT:   prdata = 32'(r_draw_h);
            REG_REGION_LEFT:   prdata = 32'(r_left);
            REG_REGION_TOP:    prdata = 32'(r_top);
            REG_LINE_PITCH:    prdata = 32'(r_pitch);
            default:           prdata = '0;
        endcase
    end

    // ---------------- pipeline ----------------
    // Advance every stage together whenever the output register can take an item.
    logic r_out_vld;
    logic en;

    assign en            = !r_out_vld || m_axis_tready;
    assign s_axis_tready = en;

    // Stage 0: capture the input item and test it against the drawing region
    logic  r_s0_vld;
    t_item r_s0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0.req     <= s_axis_tuser[0];
            r_s0.idx     <= s_axis_tdata[15:0];
            r_s0.rgb     <= {s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]};
            r_s0.col     <= s_axis_tdata[51:40];
            r_s0.row     <= s_axis_tdata[63:52];
            r_s0.in_draw <= ({1'b0, s_axis_tdata[51:40]} < r_draw_w)
                            && ({1'b0, s_axis_tdata[63:52]} < r_draw_h);
        end
    end

    // Stage 1: row * source_height
    logic              r_s1_vld;
    t_item             r_s1;
    logic [PROD_W-1:0] r_s1_prod_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= r_s0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1        <= r_s0;
            r_s1_prod_y <= PROD_W'(r_s0.row) * PROD_W'(r_src_h);
        end
    end

    // Row divider: source row = row * source_height / draw_height
    logic              dy_vld;
    logic [SIZE_W-1:0] dy_q;
    t_item             dy_pay;

    nns_div #(
        .NW (PROD_W),
        .DW (SIZE_W),
        .QW (SIZE_W),
        .PW ($bits(t_item))
    ) u_div_row (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (r_s1_vld),
        .i_dividend  (r_s1_prod_y),
        .i_divisor   (r_draw_h),
        .i_payload   (r_s1),
        .o_valid     (dy_vld),
        .o_quotient  (dy_q),
        .o_remainder (),
        .o_payload   (dy_pay)
    );

    // Stage 2: clamp the source row, col * source_width
    logic              r_s2_vld;
    t_item_y           r_s2;
    logic [PROD_W-1:0] r_s2_prod_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld <= dy_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2.item   <= dy_pay;
            r_s2.sy     <= clamp_coord(dy_q, r_src_h);
            r_s2_prod_x <= PROD_W'(dy_pay.col) * PROD_W'(r_src_w);
        end
    end

    // Column divider: source column = col * source_width / draw_width
    logic              dx_vld;
    logic [SIZE_W-1:0] dx_q;
    t_item_y           dx_pay;

    nns_div #(
        .NW (PROD_W),
        .DW (SIZE_W),
        .QW (SIZE_W),
        .PW ($bits(t_item_y))
    ) u_div_col (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (r_s2_vld),
        .i_dividend  (r_s2_prod_x),
        .i_divisor   (r_draw_w),
        .i_payload   (r_s2),
        .o_valid     (dx_vld),
        .o_quotient  (dx_q),
        .o_remainder (),
        .o_payload   (dx_pay)
    );

    // Stage 3: clamp the source column
    logic              r_s3_vld;
    t_item_y           r_s3;
    logic [SIZE_W-1:0] r_s3_sx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (en) begin
            r_s3_vld <= dx_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3    <= dx_pay;
            r_s3_sx <= clamp_coord(dx_q, r_src_w);
        end
    end

    // Stage 4: source row * width, absolute framebuffer row and column
    logic              r_s4_vld;
    t_item             r_s4;
    logic [LIN_W-1:0]  r_s4_lin;
    logic [SIZE_W-1:0] r_s4_sx;
    logic [SIZE_W-1:0] r_s4_rowabs;
    logic [SIZE_W-1:0] r_s4_colabs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (en) begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4        <= r_s3.item;
            r_s4_lin    <= LIN_W'(r_s3.sy) * LIN_W'(r_src_w);
            r_s4_sx     <= r_s3_sx;
            r_s4_rowabs <= SIZE_W'(r_top) + SIZE_W'(r_s3.item.row);
            r_s4_colabs <= SIZE_W'(r_left) + SIZE_W'(r_s3.item.col);
        end
    end

    // Stage 5: linear source index, absolute row * pitch
    logic             r_s5_vld;
    t_addr_part       r_s5;
    logic [SUM_W-1:0] r_s5_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else if (en) begin
            r_s5_vld <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5.item   <= r_s4;
            r_s5.fprod  <= FPROD_W'(r_s4_rowabs) * FPROD_W'(r_pitch);
            r_s5.colabs <= r_s4_colabs;
            r_s5_sum    <= SUM_W'(r_s4_lin) + SUM_W'(r_s4_sx);
        end
    end

    // Wrap the source index into the store
    logic          m_vld;
    logic [IW-1:0] m_idx;
    t_addr_part    m_pay;

    if (POW2) begin : g_wrap_mask
        assign m_vld = r_s5_vld;
        assign m_idx = r_s5_sum[IW-1:0];
        assign m_pay = r_s5;
    end else begin : g_wrap_mod
        // Estimate the quotient with a scaled reciprocal; it is at most one low,
        // so one compare and subtract finishes the remainder.
        localparam int LOG_P   = $clog2(SOURCE_PIXELS);
        localparam int SHIFT   = SUM_W + LOG_P;
        localparam int RECIP_W = SUM_W + 1;
        localparam int MPROD_W = SUM_W + RECIP_W;
        localparam logic [RECIP_W-1:0] RECIP =
            RECIP_W'((64'd1 << SHIFT) / 64'(SOURCE_PIXELS));
        localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(SOURCE_PIXELS);
        localparam logic [MW-1:0]    DEPTH_M = MW'(SOURCE_PIXELS);

        logic               r_a_vld, r_b_vld, r_c_vld;
        t_addr_part         r_a_pay, r_b_pay, r_c_pay;
        logic [SUM_W-1:0]   r_a_sum;
        logic [MPROD_W-1:0] r_a_prod;
        logic [SUM_W-1:0]   quo;
        logic [MW-1:0]      r_b_rem;
        logic [IW-1:0]      r_c_idx;

        assign quo = SUM_W'(r_a_prod >> SHIFT);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_vld <= 1'b0;
                r_b_vld <= 1'b0;
                r_c_vld <= 1'b0;
            end else if (en) begin
                r_a_vld <= r_s5_vld;
                r_b_vld <= r_a_vld;
                r_c_vld <= r_b_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_a_pay  <= r_s5;
                r_a_sum  <= r_s5_sum;
                r_a_prod <= MPROD_W'(r_s5_sum) * MPROD_W'(RECIP);
                r_b_pay  <= r_a_pay;
                r_b_rem  <= MW'(r_a_sum - quo * DEPTH_S);
                r_c_pay  <= r_b_pay;
                r_c_idx  <= (r_b_rem >= DEPTH_M) ? IW'(r_b_rem - DEPTH_M) : IW'(r_b_rem);
            end
        end

        assign m_vld = r_c_vld;
        assign m_idx = r_c_idx;
        assign m_pay = r_c_pay;
    end

    // Stage 6: framebuffer address; drives the store access
    logic              r_s6_vld;
    t_item             r_s6;
    logic [IW-1:0]     r_s6_sidx;
    logic [ADDR_W-1:0] r_s6_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld <= 1'b0;
        end else if (en) begin
            r_s6_vld <= m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s6      <= m_pay.item;
            r_s6_sidx <= m_idx;
            r_s6_addr <= ADDR_W'(m_pay.fprod + FPROD_W'(m_pay.colabs));
        end
    end

    // Loads write here and renders read here, so the store sees items in order.
    // Drop loads whose index falls beyond the store.
    logic             ram_we;
    logic [RGB_W-1:0] ram_rdata;

    assign ram_we = en && r_s6_vld && (r_s6.req == REQ_LOAD)
                    && (32'(r_s6.idx) < 32'(SOURCE_PIXELS));

    nns_ram #(
        .WIDTH (RGB_W),
        .DEPTH (SOURCE_PIXELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (IW'(r_s6.idx)),
        .i_wdata (r_s6.rgb),
        .i_re    (en),
        .i_raddr (r_s6_sidx),
        .o_rdata (ram_rdata)
    );

    // Stage 7: output register, pairs with the store's read register
    logic [ADDR_W-1:0] r_out_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_s6_vld && (r_s6.req == REQ_RENDER) && r_s6.in_draw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_addr <= r_s6_addr;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'b0, ram_rdata, r_out_addr};

endmodule

@@ dv/tb_nearest_neighbor_scale_blit.sv @@
`timescale 1ns / 1ps

module tb_nearest_neighbor_scale_blit;
    import nns_pkg::*;

    localparam int LATENCY       = 33;
    localparam int SETTLE_CYCLES = LATENCY + 16;  // let loads and dropped renders clear the pipe
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 400;
    localparam int STORE_DEPTH   = 65536;

    // One input item, unpacked into its fields
    typedef struct {
        logic             kind;
        logic [IDX_W-1:0] index;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
    } t_scaler_req;

    // One framebuffer write the block should emit
    typedef struct {
        logic [ADDR_W-1:0] address;
        logic [RGB_W-1:0]  pixel;
    } t_blit_word;

    typedef struct {
        int unsigned src_w;
        int unsigned src_h;
        int unsigned dst_w;
        int unsigned dst_h;
        int unsigned left;
        int unsigned top;
        int unsigned pitch;
    } t_geometry;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // [15:0] index, [23:16] red, [31:24] green, [39:32] blue,
                                 // [51:40] col, [63:52] row
    logic [0:0]  s_axis_tuser;   // [0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // [25:0] frame_address, [49:26] xrgb_pixel, [55:50] zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Scoreboard state: shadow of the registers and of the source store
    t_geometry        geo;
    logic [RGB_W-1:0] image_copy [STORE_DEPTH];
    bit               loaded [STORE_DEPTH];
    t_blit_word       expected_words [$];

    int  errors;
    int  items_sent;
    int  loads_sent;
    int  renders_sent;
    int  pixels_checked;
    int  settings_used;
    int  cycle_count;
    bit  source_no_gap;
    bit  sink_no_stall;

    nearest_neighbor_scale_blit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or drops items
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_words.size());
        $display("status: fail");
        $finish;
    end

    task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
        if (errors < 40) begin
            $display("[%0t] mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
        end
        errors++;
    endtask

    // Nearest source coordinate along one axis; clamp to the last row/column
    function automatic int unsigned nearest_source(int unsigned pos, int unsigned src,
                                                   int unsigned dst);
        int unsigned s;
        s = (pos * src) / dst;
        if (s >= src) begin
            s = (src == 0) ? 0 : src - 1;
        end
        return s;
    endfunction

    function automatic bit in_region(logic [POS_W-1:0] col, logic [POS_W-1:0] row);
        return (col < geo.dst_w) && (row < geo.dst_h);
    endfunction

    // Store slot a render reads; wraps modulo the store depth
    function automatic logic [IDX_W-1:0] source_slot(logic [POS_W-1:0] col,
                                                     logic [POS_W-1:0] row);
        longint unsigned sx;
        longint unsigned sy;
        longint unsigned lin;
        sy  = nearest_source(32'(row), geo.src_h, geo.dst_h);
        sx  = nearest_source(32'(col), geo.src_w, geo.dst_w);
        lin = sy * geo.src_w + sx;
        return IDX_W'(lin % STORE_DEPTH);
    endfunction

    // Advance the shadow model by one accepted item
    function automatic void absorb_item(t_scaler_req it);
        t_blit_word w;
        logic [63:0] addr;
        if (it.kind == REQ_LOAD) begin
            image_copy[it.index] = {it.red, it.green, it.blue};
            loaded[it.index]     = 1'b1;
            loads_sent++;
        end else begin
            renders_sent++;
            if (in_region(it.col, it.row)) begin
                addr = (64'(geo.top) + 64'(it.row)) * 64'(geo.pitch)
                     + 64'(geo.left) + 64'(it.col);
                w.address = addr[ADDR_W-1:0];   // drop address overflow
                w.pixel   = image_copy[source_slot(it.col, it.row)];
                expected_words.push_back(w);
            end
        end
    endfunction

    function automatic t_scaler_req random_fill(logic kind);
        t_scaler_req it;
        it.kind  = kind;
        it.index = IDX_W'($urandom);
        it.red   = 8'($urandom);
        it.green = 8'($urandom);
        it.blue  = 8'($urandom);
        it.col   = POS_W'($urandom);
        it.row   = POS_W'($urandom);
        return it;
    endfunction

    // Present one item after a random gap and hold it until accepted
    task automatic send_item(t_scaler_req it);
        int gap;
        gap = source_no_gap ? 0 : $urandom_range(0, 9);
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.kind;
        s_axis_tdata  <= {it.row, it.col, it.blue, it.green, it.red, it.index};
        do @(posedge i_clk); while (!s_axis_tready);
        absorb_item(it);
        items_sent++;
    endtask

    task automatic load_pixel(logic [IDX_W-1:0] index, logic [RGB_W-1:0] rgb);
        t_scaler_req it;
        it = random_fill(REQ_LOAD);
        it.index = index;
        {it.red, it.green, it.blue} = rgb;
        send_item(it);
    endtask

    // Render one pixel; for an in-region pixel, load its source slot first if it was never written
    task automatic render_pixel(logic [POS_W-1:0] col, logic [POS_W-1:0] row);
        t_scaler_req it;
        if (in_region(col, row) && !loaded[source_slot(col, row)]) begin
            load_pixel(source_slot(col, row), RGB_W'($urandom));
        end
        it = random_fill(REQ_RENDER);
        it.col = col;
        it.row = row;
        send_item(it);
    endtask

    // Drop valid and wait for every expected pixel; optionally let the pipe settle
    task automatic hold_until_drained(bit settle);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        if (settle) begin
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end
    endtask

    // Write one register, then read it back in a second transfer
    task automatic apb_write(logic [2:0] reg_index, int unsigned value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (reg_index)
            REG_SOURCE_WIDTH:  geo.src_w = value;
            REG_SOURCE_HEIGHT: geo.src_h = value;
            REG_DRAW_WIDTH:    geo.dst_w = value;
            REG_DRAW_HEIGHT:   geo.dst_h = value;
            REG_REGION_LEFT:   geo.left  = value;
            REG_REGION_TOP:    geo.top   = value;
            REG_LINE_PITCH:    geo.pitch = value;
            default: ;
        endcase
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== value) begin
            flag_mismatch("register readback", 64'(prdata), 64'(value));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Reprogram the whole geometry, only once the block is idle
    task automatic set_geometry(t_geometry g);
        hold_until_drained(1'b1);
        apb_write(REG_SOURCE_WIDTH,  g.src_w);
        apb_write(REG_SOURCE_HEIGHT, g.src_h);
        apb_write(REG_DRAW_WIDTH,    g.dst_w);
        apb_write(REG_DRAW_HEIGHT,   g.dst_h);
        apb_write(REG_REGION_LEFT,   g.left);
        apb_write(REG_REGION_TOP,    g.top);
        apb_write(REG_LINE_PITCH,    g.pitch);
        settings_used++;
    endtask

    // Mostly small sizes, now and then the full range
    function automatic int unsigned random_extent(bit is_source);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return (is_source && $urandom_range(0, 1)) ? 8191 : 4096;
        if (pick == 1) return 1;
        if (pick == 2) return $urandom_range(1, 4096);
        return $urandom_range(1, 24);
    endfunction

    // Region offset: anywhere, or pinned to 0 or to 4095
    function automatic int unsigned random_offset();
        if ($urandom_range(0, 1)) return $urandom_range(0, 4095);
        return 4095 * $urandom_range(0, 1);
    endfunction

    // Reset values: 1x1 source into a 1x1 region at the origin, pitch 1
    task automatic test_reset_defaults();
        load_pixel(16'h0000, 24'hFFFFFF);
        render_pixel(12'd0, 12'd0);
        render_pixel(12'd1, 12'd0);
        render_pixel(12'd0, 12'd1);
    endtask

    // Tiny source blown up to the largest region at the far corner
    task automatic test_upscale_extremes();
        set_geometry('{2, 2, 4096, 4096, 4095, 4095, 8192});
        load_pixel(16'd0, 24'hFF0000);
        load_pixel(16'd1, 24'h00FF00);
        load_pixel(16'd2, 24'h0000FF);
        load_pixel(16'd3, 24'hFFFFFF);
        load_pixel(16'hFFFF, 24'h000000);
        render_pixel(12'd0, 12'd0);
        render_pixel(12'd4095, 12'd0);
        render_pixel(12'd0, 12'd4095);
        render_pixel(12'd4095, 12'd4095);
    endtask

    // Zero source size clamps to slot zero; zero draw size never renders
    task automatic test_zero_sizes();
        set_geometry('{0, 0, 3, 3, 7, 2, 9});
        render_pixel(12'd2, 12'd2);
        set_geometry('{5, 5, 0, 0, 0, 0, 1});
        render_pixel(12'd0, 12'd0);
        render_pixel(12'd4095, 12'd4095);
    endtask

    // Big source wraps the store index; full pitch overflows the 26-bit address
    task automatic test_store_wrap();
        set_geometry('{4096, 4096, 4096, 4096, 4095, 4095, 16383});
        render_pixel(12'd4095, 12'd4095);
        render_pixel(12'd100, 12'd4000);
        render_pixel(12'd4095, 12'd0);
    endtask

    // Random geometries, each phase a mix of loads, raster runs and stray renders
    task automatic test_random_phases();
        t_geometry        g;
        int               stop_at;
        int               phase;
        int               length;
        int               pick;
        int               n;
        logic [POS_W-1:0] c;
        logic [POS_W-1:0] r;
        stop_at = items_sent + RANDOM_ITEMS;
        phase   = 0;
        while (items_sent < stop_at) begin
            case (phase)
                0: g = '{1, 1, 1, 1, 0, 0, 1};
                1: g = '{4096, 4096, 4096, 4096, 4095, 4095, 8192};
                default: begin
                    g.src_w = random_extent(1'b1);
                    g.src_h = random_extent(1'b1);
                    g.dst_w = random_extent(1'b0);
                    g.dst_h = random_extent(1'b0);
                    g.left  = random_offset();
                    g.top   = random_offset();
                    g.pitch = $urandom_range(0, 3) ? $urandom_range(1, 8192) : 8192;
                end
            endcase
            set_geometry(g);
            source_no_gap = (phase % 3 == 1);
            sink_no_stall = (phase % 4 == 2);
            length = $urandom_range(30, 60);
            for (n = 0; n < length; n++) begin
                // halfway through, starve the block until it has caught up
                if (n == length / 2) hold_until_drained(1'b0);
                pick = $urandom_range(0, 99);
                if (pick < 15) begin
                    load_pixel(IDX_W'($urandom), RGB_W'($urandom));
                end else if (pick < 25) begin
                    render_pixel(POS_W'($urandom), POS_W'($urandom));
                end else if (pick < 40) begin
                    // short raster run along one output row
                    c = POS_W'($urandom_range(0, g.dst_w - 1));
                    r = POS_W'($urandom_range(0, g.dst_h - 1));
                    repeat (6) begin
                        if (c < g.dst_w) render_pixel(c, r);
                        c++;
                    end
                end else begin
                    render_pixel(POS_W'($urandom_range(0, g.dst_w - 1)),
                                 POS_W'($urandom_range(0, g.dst_h - 1)));
                end
            end
            phase++;
        end
        source_no_gap = 1'b0;
        sink_no_stall = 1'b0;
    endtask

    // Receiver: stall a random number of cycles before taking each result
    initial begin : result_sink
        int stall;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        m_axis_tready <= 1'b1;
        forever begin
            stall = sink_no_stall ? 0 : $urandom_range(0, 9);
            if (stall != 0) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Compare each accepted result with the oldest expected pixel
    always @(posedge i_clk) begin
        t_blit_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                flag_mismatch("result with nothing pending", 64'(m_axis_tdata), 64'd0);
            end else begin
                want = expected_words.pop_front();
                pixels_checked++;
                if (m_axis_tdata[25:0] !== want.address) begin
                    flag_mismatch("frame_address", 64'(m_axis_tdata[25:0]),
                                  64'(want.address));
                end
                if (m_axis_tdata[49:26] !== want.pixel) begin
                    flag_mismatch("xrgb_pixel", 64'(m_axis_tdata[49:26]), 64'(want.pixel));
                end
                if (m_axis_tdata[55:50] !== 6'd0) begin
                    flag_mismatch("tdata padding", 64'(m_axis_tdata[55:50]), 64'd0);
                end
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        errors         = 0;
        items_sent     = 0;
        loads_sent     = 0;
        renders_sent   = 0;
        pixels_checked = 0;
        settings_used  = 0;
        source_no_gap  = 1'b0;
        sink_no_stall  = 1'b0;
        geo            = '{1, 1, 1, 1, 0, 0, 1};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_upscale_extremes();
        test_zero_sizes();
        test_store_wrap();
        test_random_phases();
        hold_until_drained(1'b1);

        $display("run: %0d items (%0d loads, %0d renders), %0d pixels compared",
                 items_sent, loads_sent, renders_sent, pixels_checked);
        $display("run: %0d geometries incl. zero sizes, 4096 regions, index wrap, address wrap",
                 settings_used);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
